// File: src/pmq_pkg.sv
// shared widths and types for the pose matrix to quaternion pipeline
package pmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ROT_W     = FRAC_BITS + 2;
  localparam int QW_W      = FRAC_BITS + 1;
  localparam int POS_W     = 24;
  localparam int T_W       = FRAC_BITS + 4;
  localparam int SQ_W      = FRAC_BITS + 1;
  localparam int RAD_W     = 2 * SQ_W;
  localparam int M_W       = FRAC_BITS + 2;
  localparam int D_W       = FRAC_BITS + 3;
  localparam int DV_W      = FRAC_BITS + 3;
  localparam int NUM_W     = M_W + FRAC_BITS;
  localparam int LANES     = 3;
  localparam int IN_W      = ((9 * ROT_W + 3 * POS_W + 7) / 8) * 8;
  localparam int OUT_W     = ((3 * POS_W + 3 * ROT_W + QW_W + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][M_W-1:0]   mag;
    logic [2:0]            sgn;
    logic                  degen;
  } sqrt_side_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [QW_W-1:0]       w;
    logic [2:0]            sgn;
    logic                  degen;
  } div_side_t;

endpackage

// File: src/pmq_sqrt.sv
// pipelined integer square root, one root bit per stage
module pmq_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pmq_pkg::RAD_W-1:0]  in_rad,
  input  pmq_pkg::sqrt_side_t        in_side,
  output logic                       out_valid,
  output logic [pmq_pkg::SQ_W-1:0]   out_root,
  output pmq_pkg::sqrt_side_t        out_side
);
  import pmq_pkg::*;

  localparam int REM_W = SQ_W + 2;

  logic [RAD_W-1:0] rad_w  [SQ_W+1];
  logic [REM_W-1:0] rem_w  [SQ_W+1];
  logic [SQ_W-1:0]  root_w [SQ_W+1];
  logic             vld_w  [SQ_W+1];
  sqrt_side_t       side_w [SQ_W+1];

  assign rad_w[0]  = in_rad;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign vld_w[0]  = in_valid;
  assign side_w[0] = in_side;

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [RAD_W-1:0] rad_r;
    logic [REM_W-1:0] rem_r, rem_nxt, cur, trial;
    logic [SQ_W-1:0]  root_r, root_nxt;
    logic             vld_r;
    sqrt_side_t       side_r;

    always_comb begin
      cur   = {rem_w[k][REM_W-3:0], rad_w[k][RAD_W-1 -: 2]};
      trial = {root_w[k], 2'b01};
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_w[k][SQ_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_w[k][SQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= {rad_w[k][RAD_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        side_r <= side_w[k];
      end
    end

    assign rad_w[k+1]  = rad_r;
    assign rem_w[k+1]  = rem_r;
    assign root_w[k+1] = root_r;
    assign vld_w[k+1]  = vld_r;
    assign side_w[k+1] = side_r;
  end

  assign out_valid = vld_w[SQ_W];
  assign out_root  = root_w[SQ_W];
  assign out_side  = side_w[SQ_W];

endmodule

// File: src/pmq_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one bit per stage
module pmq_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][pmq_pkg::NUM_W-1:0]        in_num,
  input  logic [pmq_pkg::DV_W-1:0]              in_dvs,
  input  pmq_pkg::div_side_t                    in_side,
  output logic                                  out_valid,
  output logic [2:0][pmq_pkg::NUM_W-1:0]        out_quo,
  output pmq_pkg::div_side_t                    out_side
);
  import pmq_pkg::*;

  localparam int R_W = DV_W + 1;

  logic [2:0][NUM_W-1:0] nq_w   [NUM_W+1];
  logic [2:0][R_W-1:0]   rem_w  [NUM_W+1];
  logic [DV_W-1:0]       dvs_w  [NUM_W+1];
  logic                  vld_w  [NUM_W+1];
  div_side_t             side_w [NUM_W+1];

  assign nq_w[0]   = in_num;
  assign rem_w[0]  = '0;
  assign dvs_w[0]  = in_dvs;
  assign vld_w[0]  = in_valid;
  assign side_w[0] = in_side;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [2:0][NUM_W-1:0] nq_r, nq_nxt;
    logic [2:0][R_W-1:0]   rem_r, rem_nxt;
    logic [DV_W-1:0]       dvs_r;
    logic                  vld_r;
    div_side_t             side_r;

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_comb begin
      logic [R_W-1:0] cur;
      for (int l = 0; l < LANES; l++) begin
        cur = {rem_w[k][l][R_W-2:0], nq_w[k][l][NUM_W-1]};
        if (cur >= {1'b0, dvs_w[k]}) begin
          rem_nxt[l] = cur - {1'b0, dvs_w[k]};
          nq_nxt[l]  = {nq_w[k][l][NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = cur;
          nq_nxt[l]  = {nq_w[k][l][NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r   <= nq_nxt;
        rem_r  <= rem_nxt;
        dvs_r  <= dvs_w[k];
        side_r <= side_w[k];
      end
    end

    assign nq_w[k+1]   = nq_r;
    assign rem_w[k+1]  = rem_r;
    assign dvs_w[k+1]  = dvs_r;
    assign vld_w[k+1]  = vld_r;
    assign side_w[k+1] = side_r;
  end

  assign out_valid = vld_w[NUM_W];
  assign out_quo   = nq_w[NUM_W];
  assign out_side  = side_w[NUM_W];

endmodule

// File: src/pose_matrix_to_quaternion.sv
// top level: pose matrix to position and quaternion, fully pipelined
//
// in_*  : one 3x4 pose per word (nine Q1.16 rotation elements, three Q7.16
//         translations), accepted when in_tvalid and in_tready are high.
// out_* : one word per pose: position with z negated and saturated, the
//         quaternion in Q1.16, and the degenerate flag on out_tuser.
// The stages are one input stage, a square root stage per root bit, one
// divisor stage, a divider stage per quotient bit and the output register.
// Throughput is one pose per cycle unless the output stalls; every stage
// holds one pose.
// When out_tready is low while a word waits, the whole pipeline holds and
// in_tready drops in the same cycle, so nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty afterwards and the
// first word may be presented in the next cycle.
// A degenerate rotation (1 + trace not positive) gives a zero quaternion
// with the flag set; the position is still valid.
module pose_matrix_to_quaternion (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // rot_00..rot_22, trans_x, trans_y, trans_z, zero pad
  input  logic [pmq_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, zero pad
  output logic [pmq_pkg::OUT_W-1:0]  out_tdata,
  // degenerate
  output logic                       out_tuser
);
  import pmq_pkg::*;

  localparam logic [QW_W-1:0]  ONE_Q = QW_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  logic en;
  assign en        = !(out_tvalid && !out_tready);
  assign in_tready = en;

  // input unpack
  logic signed [ROT_W-1:0] rot [9];
  logic [POS_W-1:0]        trn [3];
  always_comb begin
    for (int i = 0; i < 9; i++) rot[i] = in_tdata[i*ROT_W +: ROT_W];
    for (int i = 0; i < 3; i++) trn[i] = in_tdata[9*ROT_W + i*POS_W +: POS_W];
  end

  // stage 0: trace, differences, position
  logic signed [T_W-1:0] t;
  logic signed [D_W-1:0] d [3];
  sqrt_side_t            side0_nxt, side0_r;
  logic [RAD_W-1:0]      rad_nxt, rad_r;
  logic                  vld0_r;

  always_comb begin
    t = T_W'($signed({1'b0, ONE_Q})) + T_W'(rot[0]) + T_W'(rot[4]) + T_W'(rot[8]);
    d[0] = D_W'(rot[7]) - D_W'(rot[5]);
    d[1] = D_W'(rot[2]) - D_W'(rot[6]);
    d[2] = D_W'(rot[3]) - D_W'(rot[1]);
    side0_nxt.pos[0] = trn[0];
    side0_nxt.pos[1] = trn[1];
    side0_nxt.pos[2] = (trn[2] == POS_MIN) ? POS_MAX : POS_W'(-trn[2]);
    for (int l = 0; l < LANES; l++) begin
      side0_nxt.sgn[l] = d[l][D_W-1];
      side0_nxt.mag[l] = d[l][D_W-1] ? M_W'(-d[l]) : M_W'(d[l]);
    end
    side0_nxt.degen = (t <= 0);
    rad_nxt = {1'b0, t[T_W-2:0], {(FRAC_BITS-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r <= side0_nxt;
      rad_r   <= rad_nxt;
    end
  end

  logic             sq_vld;
  logic [SQ_W-1:0]  sq_root;
  sqrt_side_t       sq_side;

  pmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld0_r),
    .in_rad    (rad_r),
    .in_side   (side0_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // divisor stage: saturate w, form 4w and the shifted dividends
  logic                  vld1_r;
  logic [2:0][NUM_W-1:0] num_nxt, num_r;
  logic [DV_W-1:0]       dvs_nxt, dvs_r;
  div_side_t             side1_nxt, side1_r;

  always_comb begin
    side1_nxt.w     = (sq_root > ONE_Q) ? ONE_Q : sq_root;
    side1_nxt.pos   = sq_side.pos;
    side1_nxt.sgn   = sq_side.sgn;
    side1_nxt.degen = sq_side.degen;
    dvs_nxt         = {side1_nxt.w, 2'b00};
    for (int l = 0; l < LANES; l++) num_nxt[l] = {sq_side.mag[l], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num_nxt;
      dvs_r   <= dvs_nxt;
      side1_r <= side1_nxt;
    end
  end

  logic                  dv_vld;
  logic [2:0][NUM_W-1:0] dv_quo;
  div_side_t             dv_side;

  pmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld1_r),
    .in_num    (num_r),
    .in_dvs    (dvs_r),
    .in_side   (side1_r),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // output stage: saturate, apply signs, clear on degenerate
  logic [ROT_W-1:0]  q_nxt [3];
  logic [QW_W-1:0]   w_nxt;
  logic [OUT_W-1:0]  data_nxt, data_r;
  logic              degen_r, vld_out_r;

  always_comb begin
    logic [QW_W-1:0] qm;
    logic            neg;
    for (int l = 0; l < LANES; l++) begin
      qm  = (dv_quo[l] > NUM_W'(ONE_Q)) ? ONE_Q : dv_quo[l][QW_W-1:0];
      // x and y flip handedness
      neg = (l == 2) ? dv_side.sgn[l] : !dv_side.sgn[l];
      q_nxt[l] = dv_side.degen ? '0 :
                 (neg ? ROT_W'(-{1'b0, qm}) : ROT_W'({1'b0, qm}));
    end
    w_nxt = dv_side.degen ? '0 : dv_side.w;
    data_nxt = '0;
    for (int i = 0; i < 3; i++) data_nxt[i*POS_W +: POS_W] = dv_side.pos[i];
    for (int l = 0; l < LANES; l++) data_nxt[3*POS_W + l*ROT_W +: ROT_W] = q_nxt[l];
    data_nxt[3*POS_W + 3*ROT_W +: QW_W] = w_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r  <= data_nxt;
      degen_r <= dv_side.degen;
    end
  end

  assign out_tvalid = vld_out_r;
  assign out_tdata  = data_r;
  assign out_tuser  = degen_r;

endmodule
